// ----- rtl/socks5_header_classifier_macros.svh -----
// ----------------------------------------------------------------------------
// SOCKS5 header classifier assertion macros
// Shared property wrappers clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SOCKS5_HEADER_CLASSIFIER_MACROS_SVH
`define SOCKS5_HEADER_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define S5HC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define S5HC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/s5hc_pkg.sv -----
// ----------------------------------------------------------------------------
// s5hc_pkg
// Types and constants shared by the SOCKS5 header classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package s5hc_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic        REG_PROXY_PORT     = 1'b0;
  localparam logic [15:0] DEFAULT_PROXY_PORT = 16'd1080;
  localparam logic [7:0]  SOCKS_VERSION      = 8'd5;

  localparam logic [7:0] ATYP_IPV4   = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN = 8'd3;
  localparam logic [7:0] ATYP_IPV6   = 8'd4;

  localparam logic KIND_ADDR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_WEAK   = 2'd1;
  localparam logic [1:0] VERDICT_STRONG = 2'd2;

  typedef enum logic [1:0] {
    MSG_NONE,
    MSG_NEGOTIATION,
    MSG_REQUEST,
    MSG_REPLY
  } msg_type_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] payload_length;
    logic [15:0] packet_port;
    logic        is_tcp;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [1:0]  verdict;
    logic [1:0]  message_type;
    logic [7:0]  command_code;
    logic [7:0]  address_type;
    logic [7:0]  address_length;
    logic [7:0]  method_count;
    logic [7:0]  first_method;
    logic [15:0] dest_port;
    logic        port_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0] byte_position;
    logic        version_ok;
    logic [7:0]  second_byte;
    logic [7:0]  reserved_byte;
    logic [7:0]  addr_type_byte;
    logic [7:0]  domain_length;
    logic [15:0] port_accumulator;
  } parse_state_t;

endpackage

`default_nettype wire

// ----- rtl/socks5_header_classifier.sv -----
// Each accepted byte waits in the input register until the output is free; the
// input register feeds one parse stage that writes the result register.
// Throughput: one byte per cycle while the output is not stalled.
// Reset: asynchronous, active low; clears the parser state and the pipeline,
// and loads proxy_port with 1080.
// ----------------------------------------------------------------------------
// socks5_header_classifier
// Classifies SOCKS5 payloads byte by byte and streams address bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module socks5_header_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  s5hc_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output s5hc_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s5hc_pkg::PADDR_W-1:0]  paddr,
  input  logic [s5hc_pkg::PDATA_W-1:0]  pwdata,
  output logic [s5hc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import s5hc_pkg::*;

  logic         s1_valid_q, s1_valid_d;
  in_item_t     s1_item_q;
  parse_state_t state_q, state_d;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_item_q;
  logic [15:0]  proxy_port_q, proxy_port_d;
  logic         out_free;
  logic         s1_fire;
  logic         in_fire;
  logic         res_valid;
  out_item_t    res_item;
  logic         reg_wr;

  s5hc_parse u_parse (
    .item_i       (s1_item_q),
    .state_i      (state_q),
    .proxy_port_i (proxy_port_q),
    .state_o      (state_d),
    .res_valid_o  (res_valid),
    .res_item_o   (res_item)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);
  assign out_valid_d = out_free ? (s1_fire && res_valid) : out_valid_q;

  assign reg_wr       = psel && penable && pwrite && pready;
  assign proxy_port_d = (reg_wr && (paddr[2] == REG_PROXY_PORT)) ? pwdata[15:0]
                                                                   : proxy_port_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROXY_PORT) ? PDATA_W'(proxy_port_q) : '0;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= '0;
      proxy_port_q <= DEFAULT_PROXY_PORT;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      proxy_port_q <= proxy_port_d;
      if (s1_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire && res_valid) begin
      out_item_q <= res_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/s5hc_parse.sv -----
// ----------------------------------------------------------------------------
// s5hc_parse
// Next parser state and result for one payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module s5hc_parse (
  input  s5hc_pkg::in_item_t     item_i,
  input  s5hc_pkg::parse_state_t state_i,
  input  logic [15:0]            proxy_port_i,
  output s5hc_pkg::parse_state_t state_o,
  output logic                   res_valid_o,
  output s5hc_pkg::out_item_t    res_item_o
);
  import s5hc_pkg::*;

  parse_state_t cur;
  logic [15:0]  p;
  logic         in_range;
  logic         is_final;
  logic         ver_n;
  logic [7:0]   sec_n;
  logic [7:0]   res_n;
  logic [7:0]   atyp_n;
  logic [7:0]   dlen_n;
  logic [15:0]  acc_n;
  logic         atyp_ok;
  logic         req_shape;
  logic         span_ok;
  logic [2:0]   start;
  logic [7:0]   alen;
  logic [8:0]   win_end;
  logic [8:0]   port_end;
  logic         in_addr;
  logic         in_port;
  logic         neg;
  logic         req;

  always_comb begin
    cur = item_i.first_byte ? '0 : state_i;
    p = cur.byte_position;
    in_range = p < item_i.payload_length;
    is_final = in_range && ((17'(p) + 17'd1) == 17'(item_i.payload_length));

    ver_n  = cur.version_ok;
    sec_n  = cur.second_byte;
    res_n  = cur.reserved_byte;
    atyp_n = cur.addr_type_byte;
    dlen_n = cur.domain_length;
    if (in_range) begin
      unique case (p)
        16'd0:   ver_n  = (item_i.data_byte == SOCKS_VERSION);
        16'd1:   sec_n  = item_i.data_byte;
        16'd2:   res_n  = item_i.data_byte;
        16'd3:   atyp_n = item_i.data_byte;
        16'd4:   dlen_n = item_i.data_byte;
        default: ;
      endcase
    end

    atyp_ok = (atyp_n == ATYP_IPV4) || (atyp_n == ATYP_DOMAIN) || (atyp_n == ATYP_IPV6);
    req_shape = (item_i.payload_length >= 16'd6) && ver_n && (res_n == 8'd0) && atyp_ok;

    span_ok = 1'b0;
    start   = 3'd0;
    alen    = 8'd0;
    if (req_shape) begin
      priority if (atyp_n == ATYP_IPV4) begin
        span_ok = item_i.payload_length >= 16'd10;
        start   = 3'd4;
        alen    = 8'd4;
      end else if (atyp_n == ATYP_DOMAIN) begin
        span_ok = 17'(item_i.payload_length) >= (17'(dlen_n) + 17'd7);
        start   = 3'd5;
        alen    = dlen_n;
      end else begin
        span_ok = item_i.payload_length >= 16'd22;
        start   = 3'd4;
        alen    = 8'd16;
      end
      if (!span_ok) begin
        start = 3'd0;
        alen  = 8'd0;
      end
    end

    win_end  = 9'(start) + 9'(alen);
    port_end = win_end + 9'd2;
    in_addr  = in_range && span_ok && (p >= 16'd4) && (p >= 16'(start)) && (p < 16'(win_end));
    in_port  = in_range && span_ok && (p >= 16'd4) && (p >= 16'(win_end)) &&
               (p < 16'(port_end));

    acc_n = cur.port_accumulator;
    if (in_port) begin
      acc_n = {cur.port_accumulator[7:0], item_i.data_byte};
    end

    state_o.byte_position    = (p == 16'hFFFF) ? p : p + 16'd1;
    state_o.version_ok       = ver_n;
    state_o.second_byte      = sec_n;
    state_o.reserved_byte    = res_n;
    state_o.addr_type_byte   = atyp_n;
    state_o.domain_length    = dlen_n;
    state_o.port_accumulator = acc_n;

    neg = (item_i.payload_length >= 16'd3) && ver_n &&
          (17'(item_i.payload_length) >= (17'(sec_n) + 17'd2));
    req = req_shape && (sec_n >= 8'd1) && (sec_n <= 8'd3);

    res_item_o  = '0;
    res_valid_o = 1'b0;
    if (is_final) begin
      res_valid_o            = 1'b1;
      res_item_o.result_kind = KIND_SUMMARY;
      if (item_i.is_tcp && (item_i.payload_length >= 16'd3) && (neg || req)) begin
        res_item_o.verdict = (item_i.packet_port == proxy_port_i) ? VERDICT_STRONG
                                                                   : VERDICT_WEAK;
      end else begin
        res_item_o.verdict = VERDICT_NONE;
      end
      if ((item_i.payload_length >= 16'd3) && ver_n) begin
        priority if (req_shape) begin
          res_item_o.message_type = (sec_n == 8'd0) ? MSG_REPLY : MSG_REQUEST;
          res_item_o.command_code = sec_n;
          res_item_o.address_type = atyp_n;
          if (span_ok) begin
            res_item_o.address_length = alen;
            res_item_o.dest_port      = acc_n;
            res_item_o.port_valid     = 1'b1;
          end
        end else if (17'(item_i.payload_length) >= (17'(sec_n) + 17'd2)) begin
          res_item_o.message_type = MSG_NEGOTIATION;
          res_item_o.method_count = sec_n;
          res_item_o.first_method = (sec_n != 8'd0) ? res_n : 8'd0;
        end else begin
          res_item_o.message_type = MSG_NONE;
        end
      end
    end else if (in_addr) begin
      res_valid_o            = 1'b1;
      res_item_o.result_kind = KIND_ADDR;
      res_item_o.addr_byte   = item_i.data_byte;
      res_item_o.addr_index  = 8'(p - 16'(start));
    end
  end

endmodule

`default_nettype wire

// ----- rtl/s5hc_checker.sv -----
// ----------------------------------------------------------------------------
// s5hc_checker
// Port-level checks on the SOCKS5 header classifier results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "socks5_header_classifier_macros.svh"

module s5hc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input s5hc_pkg::out_item_t out_item_o
);
  import s5hc_pkg::*;

  `S5HC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")

  `S5HC_ASSERT_NOW(a_addr_clean, out_valid_o && (out_item_o.result_kind == KIND_ADDR), (out_item_o.verdict == VERDICT_NONE) && (out_item_o.message_type == MSG_NONE) && !out_item_o.port_valid, "address byte carries summary fields")

  `S5HC_ASSERT_NOW(a_port_kind, out_valid_o && (out_item_o.result_kind == KIND_SUMMARY) && out_item_o.port_valid, (out_item_o.message_type == MSG_REQUEST) || (out_item_o.message_type == MSG_REPLY), "port valid outside request or reply")

  `S5HC_ASSERT_NOW(a_none_empty, out_valid_o && (out_item_o.result_kind == KIND_SUMMARY) && (out_item_o.message_type == MSG_NONE), (out_item_o.method_count == 8'd0) && (out_item_o.address_length == 8'd0) && (out_item_o.dest_port == 16'd0), "empty summary has fields set")

endmodule

bind socks5_header_classifier s5hc_checker u_s5hc_checker (.*);

`default_nettype wire
